### sv/swh_pkg.sv
// shared types, constants and a helper function for the pattern word histogram
package swh_pkg;

  localparam int WINDOW_MAX = 1024;
  localparam int WORD_MAX   = 7;
  localparam int RING_DEPTH = WINDOW_MAX + 1;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int WL_W       = 11;
  localparam int WD_W       = 3;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 29;
  localparam int SQ_W       = 45;
  localparam int MAG_W      = 26;
  localparam int SEEN_W     = 13;
  localparam int SEEN_MAX   = 8191;
  localparam int HIST_AW    = 14;
  localparam int CNT_W      = 13;
  localparam int COUNT_MAX  = 8191;
  localparam int MUL_A_W    = 52;
  localparam int MUL_B_W    = 48;
  localparam int MUL_D_W    = 16;
  localparam int MUL_P_W    = 100;
  localparam int RECIP_SH   = 20;
  localparam int RECIP_W    = RECIP_SH + 1;
  localparam int NUM_W      = 13;
  localparam int CFG_WORD_LEN   = 0;
  localparam int CFG_WINDOW_LEN = 1;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       series_start;
    logic [HIST_AW-1:0]         bin_index;
  } swh_in_t;

  typedef struct packed {
    logic               word_valid;
    logic [HIST_AW-1:0] word;
    logic               counted;
    logic [CNT_W-1:0]   bin_count;
  } swh_out_t;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_ACCEPT, ACT_CLR, ACT_PUSH, ACT_BASE, ACT_BASEW, ACT_MSTART, ACT_MLATCH,
    ACT_SEGB, ACT_SEGW, ACT_SYM, ACT_WORD, ACT_HRD, ACT_HWR, ACT_RDA, ACT_LOAD
  } swh_act_t;

  typedef enum logic [3:0] {
    ST_QWL, ST_SS, ST_TWL, ST_SLEN, ST_D100, ST_DSQ, ST_LL, ST_C, ST_VC
  } swh_step_t;

  typedef struct packed {
    swh_act_t  act;
    swh_step_t step;
  } swh_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_read;
    logic series_start;
    logic window_ok;
    logic flat;
    logic last_seg;
    logic mul_busy;
    logic word_new;
    logic out_busy;
  } swh_stat_t;

  // ceil(2^20 / wd) for the segment bound division
  function automatic logic [RECIP_W-1:0] swh_recip(input logic [WD_W-1:0] wd);
    logic [RECIP_W-1:0] r;
    case (wd)
      3'd2:    r = RECIP_W'(524288);
      3'd3:    r = RECIP_W'(349526);
      3'd4:    r = RECIP_W'(262144);
      3'd5:    r = RECIP_W'(209716);
      3'd6:    r = RECIP_W'(174763);
      3'd7:    r = RECIP_W'(149797);
      default: r = RECIP_W'(1048576);
    endcase
    return r;
  endfunction

endpackage

### sv/swh_mul.sv
// digit-serial multiplier, sixteen bits of the second operand per cycle
module swh_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [swh_pkg::MUL_A_W-1:0] a,
  input  logic [swh_pkg::MUL_B_W-1:0] b,
  input  logic [1:0]                  ndig,
  output logic                        busy,
  output logic [swh_pkg::MUL_P_W-1:0] prod
);
  import swh_pkg::*;

  logic [MUL_A_W-1:0]         a_r;
  logic [MUL_B_W-1:0]         b_r;
  logic [1:0]                 cnt_r, last_r;
  logic                       busy_r;
  logic [MUL_P_W-1:0]         acc_r, acc_nxt;
  logic [MUL_D_W-1:0]         dig;
  logic [MUL_A_W+MUL_D_W-1:0] part;
  logic [MUL_B_W-1:0]         b_sh;

  always_comb begin
    b_sh    = b_r >> {cnt_r, 4'b0000};
    dig     = b_sh[MUL_D_W-1:0];
    part    = (MUL_A_W+MUL_D_W)'(a_r) * (MUL_A_W+MUL_D_W)'(dig);
    acc_nxt = acc_r + (MUL_P_W'(part) << {cnt_r, 4'b0000});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      last_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      last_r <= ndig - 2'd1;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 2'd1;
      if (cnt_r == last_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign busy = busy_r;
  assign prod = acc_r;

endmodule

### sv/swh_dp.sv
// datapath: prefix rings, histogram memory, window arithmetic and result register
module swh_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  swh_pkg::swh_cmd_t            cmd,
  output swh_pkg::swh_stat_t           stat,
  input  swh_pkg::swh_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output swh_pkg::swh_out_t            out_data,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [swh_pkg::WL_W-1:0]     cfg_wdata
);
  import swh_pkg::*;

  // configuration
  logic [WD_W-1:0] wd_cfg_r;
  logic [WL_W-1:0] wl_cfg_r;
  logic [WD_W-1:0] wd_c;
  logic [WL_W-1:0] wl_c;

  // series state
  swh_in_t             item_r;
  logic [RING_AW-1:0]  head_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SQ_W-1:0]     sq_r;
  logic [SEEN_W-1:0]   seen_r;
  logic                prev_valid_r;
  logic [HIST_AW-1:0]  prev_word_r;
  logic [HIST_AW-1:0]  clr_idx_r;

  // window working registers
  logic [RING_AW-1:0]  base_r;
  logic                base_zero_r;
  logic                s_neg_r;
  logic [MAG_W-1:0]    smag_r;
  logic [SQ_W-1:0]     q_r;
  logic [MUL_A_W-1:0]  qwl_r, v_r;
  logic                flat_r;
  logic [WD_W-1:0]     k_r;
  logic [NUM_W-1:0]    kacc_r;
  logic [RING_AW-1:0]  lo_r, u_r, len_r;
  logic [SUM_W-1:0]    pl_r;
  logic                t_neg_r;
  logic [MAG_W-1:0]    tmag_r;
  logic [35:0]         p1_r;
  logic                d_neg_r;
  logic [36:0]         dmag_r;
  logic [43:0]         e_r;
  logic [20:0]         ll_r;
  logic [33:0]         c_r;
  logic [MUL_P_W-1:0]  lhs_r, rhs_r;
  logic [HIST_AW-1:0]  word_r;
  logic                word_valid_r, counted_r;
  logic                out_valid_r;
  swh_out_t            out_r;

  // memories
  logic [SUM_W-1:0]    sum_mem [RING_DEPTH];
  logic [SQ_W-1:0]     sq_mem  [RING_DEPTH];
  logic [CNT_W-1:0]    hist_mem [2**HIST_AW];
  logic [SUM_W-1:0]    rdsum_r;
  logic [SQ_W-1:0]     rdsq_r;
  logic [CNT_W-1:0]    hrd_r;

  // combinational helpers
  logic                ring_we, ring_re;
  logic [RING_AW-1:0]  ring_waddr, ring_raddr;
  logic [SUM_W-1:0]    sum_new, sum_base;
  logic [SQ_W-1:0]     sq_new, sq_base;
  logic signed [31:0]  xsq;
  logic [RING_AW-1:0]  head_new;
  logic [SEEN_W-1:0]   seen_new;
  logic [RING_AW:0]    base_wrap, seg_sum;
  logic [RING_AW-1:0]  base_c, seg_addr;
  logic [NUM_W-1:0]    num_c;
  logic [33:0]         rprod;
  logic [RING_AW-1:0]  u_c;
  logic [SUM_W-1:0]    pb, s_c, s_abs, t_c, t_abs;
  logic [SQ_W-1:0]     pq;
  logic [37:0]         a1, a2, d_c, d_abs;
  logic [1:0]          sym;
  logic                hist_we, hist_re;
  logic [HIST_AW-1:0]  hist_waddr, hist_raddr;
  logic [CNT_W-1:0]    hist_wdata;
  logic                mul_start, mul_busy;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [1:0]          mul_nd;
  logic [MUL_P_W-1:0]  prod;
  logic                word_new;

  swh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .ndig  (mul_nd),
    .busy  (mul_busy),
    .prod  (prod)
  );

  // clamped configuration
  always_comb begin
    wd_c = (wd_cfg_r == '0) ? WD_W'(1) : wd_cfg_r;
    wl_c = wl_cfg_r;
    if (wl_c < WL_W'(2)) wl_c = WL_W'(2);
    if (wl_c < WL_W'(wd_c)) wl_c = WL_W'(wd_c);
    if (wl_c > WL_W'(WINDOW_MAX)) wl_c = WL_W'(WINDOW_MAX);
  end

  // sample push
  always_comb begin
    sum_base = item_r.series_start ? '0 : sum_r;
    sq_base  = item_r.series_start ? '0 : sq_r;
    xsq      = item_r.sample * item_r.sample;
    sum_new  = sum_base + {{(SUM_W-SAMPLE_W){item_r.sample[SAMPLE_W-1]}}, item_r.sample};
    sq_new   = sq_base + SQ_W'(xsq[30:0]);
    if (item_r.series_start) begin
      head_new = RING_AW'(1);
    end else if (head_r == RING_AW'(RING_DEPTH - 1)) begin
      head_new = '0;
    end else begin
      head_new = head_r + RING_AW'(1);
    end
    if (item_r.series_start) begin
      seen_new = SEEN_W'(1);
    end else if (seen_r == SEEN_W'(SEEN_MAX)) begin
      seen_new = seen_r;
    end else begin
      seen_new = seen_r + SEEN_W'(1);
    end
  end

  // ring addressing and segment bounds
  always_comb begin
    if (head_r >= wl_c) begin
      base_wrap = {1'b0, head_r} - {1'b0, wl_c};
    end else begin
      base_wrap = {1'b0, head_r} + (RING_AW+1)'(RING_DEPTH) - {1'b0, wl_c};
    end
    base_c = base_wrap[RING_AW-1:0];
    num_c  = kacc_r + NUM_W'(wl_c) + NUM_W'(wd_c >> 1);
    rprod  = 34'(num_c) * 34'(swh_recip(wd_c));
    u_c    = rprod[RECIP_SH+RING_AW-1:RECIP_SH];
    seg_sum = {1'b0, base_r} + {1'b0, u_c};
    if (seg_sum >= (RING_AW+1)'(RING_DEPTH)) begin
      seg_sum = seg_sum - (RING_AW+1)'(RING_DEPTH);
    end
    seg_addr   = seg_sum[RING_AW-1:0];
    ring_we    = (cmd.act == ACT_PUSH);
    ring_waddr = head_new;
    ring_re    = (cmd.act == ACT_BASE) || (cmd.act == ACT_SEGB);
    ring_raddr = (cmd.act == ACT_BASE) ? base_c : seg_addr;
  end

  // window and segment sums
  always_comb begin
    pb    = base_zero_r ? '0 : rdsum_r;
    pq    = base_zero_r ? '0 : rdsq_r;
    s_c   = sum_r - pb;
    s_abs = s_c[SUM_W-1] ? (~s_c + SUM_W'(1)) : s_c;
    t_c   = rdsum_r - pl_r;
    t_abs = t_c[SUM_W-1] ? (~t_c + SUM_W'(1)) : t_c;
    a1    = t_neg_r ? (38'd0 - 38'(p1_r)) : 38'(p1_r);
    a2    = s_neg_r ? (38'd0 - 38'(prod[35:0])) : 38'(prod[35:0]);
    d_c   = a1 - a2;
    d_abs = d_c[37] ? (38'd0 - d_c) : d_c;
  end

  // multiplier operands
  always_comb begin
    mul_start = (cmd.act == ACT_MSTART);
    mul_a     = '0;
    mul_b     = '0;
    mul_nd    = 2'd1;
    case (cmd.step)
      ST_QWL: begin
        mul_a = MUL_A_W'(q_r);
        mul_b = MUL_B_W'(wl_c);
      end
      ST_SS: begin
        mul_a  = MUL_A_W'(smag_r);
        mul_b  = MUL_B_W'(smag_r);
        mul_nd = 2'd2;
      end
      ST_TWL: begin
        mul_a = MUL_A_W'(tmag_r);
        mul_b = MUL_B_W'(wl_c);
      end
      ST_SLEN: begin
        mul_a = MUL_A_W'(smag_r);
        mul_b = MUL_B_W'(len_r);
      end
      ST_D100: begin
        mul_a = MUL_A_W'(dmag_r);
        mul_b = MUL_B_W'(100);
      end
      ST_DSQ: begin
        mul_a  = MUL_A_W'(e_r);
        mul_b  = MUL_B_W'(e_r);
        mul_nd = 2'd3;
      end
      ST_LL: begin
        mul_a = MUL_A_W'(len_r);
        mul_b = MUL_B_W'(len_r);
      end
      ST_C: begin
        mul_a = MUL_A_W'(ll_r);
        mul_b = MUL_B_W'(4489);
      end
      ST_VC: begin
        mul_a  = v_r;
        mul_b  = MUL_B_W'(c_r);
        mul_nd = 2'd3;
      end
      default: begin
        mul_nd = 2'd1;
      end
    endcase
  end

  // symbol decision
  always_comb begin
    if (flat_r) begin
      sym = 2'd3;
    end else if (d_neg_r) begin
      sym = (lhs_r > rhs_r) ? 2'd0 : 2'd1;
    end else begin
      sym = (lhs_r < rhs_r) ? 2'd2 : 2'd3;
    end
    word_new = !prev_valid_r || (prev_word_r != word_r);
  end

  // histogram port
  always_comb begin
    hist_we    = (cmd.act == ACT_CLR) || (cmd.act == ACT_HWR);
    hist_waddr = (cmd.act == ACT_CLR) ? clr_idx_r : word_r;
    hist_wdata = '0;
    if (cmd.act == ACT_HWR) begin
      hist_wdata = (hrd_r == CNT_W'(COUNT_MAX)) ? hrd_r : hrd_r + CNT_W'(1);
    end
    hist_re    = (cmd.act == ACT_HRD) || (cmd.act == ACT_RDA);
    hist_raddr = (cmd.act == ACT_RDA) ? item_r.bin_index : word_r;
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      sum_mem[ring_waddr] <= sum_new;
      sq_mem[ring_waddr]  <= sq_new;
    end
    if (ring_re) begin
      rdsum_r <= sum_mem[ring_raddr];
      rdsq_r  <= sq_mem[ring_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hrd_r <= hist_mem[hist_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_cfg_r     <= WD_W'(3);
      wl_cfg_r     <= WL_W'(10);
      head_r       <= '0;
      sum_r        <= '0;
      sq_r         <= '0;
      seen_r       <= '0;
      prev_valid_r <= 1'b0;
      clr_idx_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'(CFG_WORD_LEN)) begin
          wd_cfg_r <= cfg_wdata[WD_W-1:0];
        end else begin
          wl_cfg_r <= cfg_wdata;
        end
      end
      if (cmd.act == ACT_CLR) begin
        clr_idx_r <= clr_idx_r + HIST_AW'(1);
      end
      if (cmd.act == ACT_PUSH) begin
        head_r <= head_new;
        sum_r  <= sum_new;
        sq_r   <= sq_new;
        seen_r <= seen_new;
        if (item_r.series_start) begin
          prev_valid_r <= 1'b0;
        end
      end
      if ((cmd.act == ACT_WORD) && word_new) begin
        prev_valid_r <= 1'b1;
      end
      if (cmd.act == ACT_LOAD) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.act)
      ACT_ACCEPT: begin
        item_r       <= in_data;
        word_r       <= '0;
        word_valid_r <= 1'b0;
        counted_r    <= 1'b0;
      end
      ACT_BASE: begin
        base_r      <= base_c;
        base_zero_r <= (seen_r == SEEN_W'(wl_c));
      end
      ACT_BASEW: begin
        s_neg_r <= s_c[SUM_W-1];
        smag_r  <= s_abs[MAG_W-1:0];
        q_r     <= sq_r - pq;
        pl_r    <= pb;
        lo_r    <= '0;
        kacc_r  <= '0;
        k_r     <= '0;
      end
      ACT_MLATCH: begin
        case (cmd.step)
          ST_QWL: qwl_r <= prod[MUL_A_W-1:0];
          ST_SS: begin
            v_r    <= qwl_r - prod[MUL_A_W-1:0];
            flat_r <= (qwl_r == prod[MUL_A_W-1:0]);
          end
          ST_TWL: p1_r <= prod[35:0];
          ST_SLEN: begin
            d_neg_r <= d_c[37];
            dmag_r  <= d_abs[36:0];
          end
          ST_D100: e_r   <= prod[43:0];
          ST_DSQ:  lhs_r <= prod;
          ST_LL:   ll_r  <= prod[20:0];
          ST_C:    c_r   <= prod[33:0];
          ST_VC:   rhs_r <= prod;
          default: rhs_r <= rhs_r;
        endcase
      end
      ACT_SEGB: begin
        u_r   <= u_c;
        len_r <= u_c - lo_r;
      end
      ACT_SEGW: begin
        t_neg_r <= t_c[SUM_W-1];
        tmag_r  <= t_abs[MAG_W-1:0];
        pl_r    <= rdsum_r;
        lo_r    <= u_r;
      end
      ACT_SYM: begin
        word_r <= word_r | (HIST_AW'(sym) << {k_r, 1'b0});
        k_r    <= k_r + WD_W'(1);
        kacc_r <= kacc_r + NUM_W'(wl_c);
      end
      ACT_WORD: begin
        word_valid_r <= 1'b1;
        counted_r    <= word_new;
        if (word_new) begin
          prev_word_r <= word_r;
        end
      end
      ACT_LOAD: begin
        out_r.word_valid <= word_valid_r;
        out_r.word       <= word_r;
        out_r.counted    <= counted_r;
        out_r.bin_count  <= item_r.op ? hrd_r : '0;
      end
      default: begin
        out_r <= out_r;
      end
    endcase
  end

  always_comb begin
    stat.clr_last     = (clr_idx_r == '1);
    stat.is_read      = in_data.op;
    stat.series_start = in_data.series_start;
    stat.window_ok    = (seen_r >= SEEN_W'(wl_c));
    stat.flat         = flat_r;
    stat.last_seg     = (k_r == wd_c - WD_W'(1));
    stat.mul_busy     = mul_busy;
    stat.word_new     = word_new;
    stat.out_busy     = out_valid_r && out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### sv/swh_ctrl.sv
// controller state machine sequencing the datapath
module swh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  swh_pkg::swh_stat_t stat,
  output swh_pkg::swh_cmd_t  cmd
);
  import swh_pkg::*;

  typedef enum logic [15:0] {
    S_CLR   = 16'h0001,
    S_IDLE  = 16'h0002,
    S_PUSH  = 16'h0004,
    S_CHK   = 16'h0008,
    S_BASE  = 16'h0010,
    S_BASEW = 16'h0020,
    S_MGO   = 16'h0040,
    S_MWAIT = 16'h0080,
    S_SEGB  = 16'h0100,
    S_SEGW  = 16'h0200,
    S_SYM   = 16'h0400,
    S_WORD  = 16'h0800,
    S_HRD   = 16'h1000,
    S_HWR   = 16'h2000,
    S_RDA   = 16'h4000,
    S_FIN   = 16'h8000
  } swh_state_t;

  swh_state_t state_r, state_nxt;
  swh_step_t  step_r, step_nxt;
  logic       clr_item_r, clr_item_nxt;
  swh_act_t   act;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    clr_item_nxt = clr_item_r;
    act          = ACT_NONE;
    unique case (state_r)
      S_CLR: begin
        act = ACT_CLR;
        if (stat.clr_last) begin
          state_nxt    = clr_item_r ? S_PUSH : S_IDLE;
          clr_item_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          act = ACT_ACCEPT;
          if (stat.is_read) begin
            state_nxt = S_RDA;
          end else if (stat.series_start) begin
            state_nxt    = S_CLR;
            clr_item_nxt = 1'b1;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end
      S_PUSH: begin
        act       = ACT_PUSH;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = stat.window_ok ? S_BASE : S_FIN;
      end
      S_BASE: begin
        act       = ACT_BASE;
        state_nxt = S_BASEW;
      end
      S_BASEW: begin
        act       = ACT_BASEW;
        step_nxt  = ST_QWL;
        state_nxt = S_MGO;
      end
      S_MGO: begin
        act       = ACT_MSTART;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (!stat.mul_busy) begin
          act       = ACT_MLATCH;
          state_nxt = S_MGO;
          case (step_r)
            ST_QWL:  step_nxt = ST_SS;
            ST_SS:   state_nxt = S_SEGB;
            ST_TWL:  step_nxt = ST_SLEN;
            ST_SLEN: step_nxt = ST_D100;
            ST_D100: step_nxt = ST_DSQ;
            ST_DSQ:  step_nxt = ST_LL;
            ST_LL:   step_nxt = ST_C;
            ST_C:    step_nxt = ST_VC;
            default: state_nxt = S_SYM;
          endcase
        end
      end
      S_SEGB: begin
        act       = ACT_SEGB;
        state_nxt = S_SEGW;
      end
      S_SEGW: begin
        act = ACT_SEGW;
        if (stat.flat) begin
          state_nxt = S_SYM;
        end else begin
          step_nxt  = ST_TWL;
          state_nxt = S_MGO;
        end
      end
      S_SYM: begin
        act       = ACT_SYM;
        state_nxt = stat.last_seg ? S_WORD : S_SEGB;
      end
      S_WORD: begin
        act       = ACT_WORD;
        state_nxt = stat.word_new ? S_HRD : S_FIN;
      end
      S_HRD: begin
        act       = ACT_HRD;
        state_nxt = S_HWR;
      end
      S_HWR: begin
        act       = ACT_HWR;
        state_nxt = S_FIN;
      end
      S_RDA: begin
        act       = ACT_RDA;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          act       = ACT_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      step_r     <= ST_QWL;
      clr_item_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      clr_item_r <= clr_item_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign cmd.act  = act;
  assign cmd.step = step_r;

endmodule

### sv/sax_word_histogram_unit.sv
// top level: one item at a time; a read item does a single histogram read, a sample short of a window
// only its ring push, and a full window runs its segments through the shared digit-serial multiplier
// (seven products per segment); a constant window skips the per-segment products
// a finished item waits in the output register while the next item is accepted
// reset is synchronous: it clears the series state and sweeps all 16384 histogram bins,
// one per cycle, before the first item; a series_start sample item repeats that sweep
module sax_word_histogram_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  swh_pkg::swh_in_t         in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output swh_pkg::swh_out_t        out_data,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [swh_pkg::WL_W-1:0] cfg_wdata
);
  import swh_pkg::*;

  swh_cmd_t  cmd;
  swh_stat_t stat;

  swh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  swh_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

### sv/swh_chk.sv
// port checker for the pattern word histogram, bound to the top level
module swh_chk (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input swh_pkg::swh_in_t         in_data,
  input logic                     out_valid,
  input logic                     out_stall,
  input swh_pkg::swh_out_t        out_data
);
  import swh_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted on consecutive cycles");

  a_no_word_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.word_valid |-> !out_data.counted && out_data.word == '0)
    else $error("word fields set without a window");

  a_no_count_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.word_valid |-> out_data.bin_count == '0)
    else $error("bin count set on a sample item");

  a_reset_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open during histogram clear");

endmodule

bind sax_word_histogram_unit swh_chk u_swh_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### bench/sax_word_histogram_unit_tb.sv
// testbench for the pattern word histogram unit: directed and random items checked against a predictor
`timescale 1ns / 100ps

module sax_word_histogram_unit_tb;
  import swh_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  swh_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  swh_out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [WL_W-1:0] cfg_wdata = '0;

  // predictor state
  longint prefix_sum [RING_DEPTH];
  longint prefix_sq [RING_DEPTH];
  int unsigned word_bins [1 << HIST_AW];
  bit prev_word_ok;
  int unsigned prev_word;
  int unsigned seen_count;
  int unsigned head_pos;
  bit [WD_W-1:0] word_len_reg;
  bit [WL_W-1:0] window_len_reg;

  swh_out_t expected_q[$];
  int errors = 0;
  int n_samples = 0;
  int n_words = 0;
  int n_reads = 0;
  int n_series = 0;
  bit quiet_send = 1'b0;
  bit quiet_recv = 1'b0;
  int hold_len = 0;
  int idle_cycles = 0;

  sax_word_histogram_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_series_state();
    for (int i = 0; i < RING_DEPTH; i++) begin
      prefix_sum[i] = 0;
      prefix_sq[i] = 0;
    end
    foreach (word_bins[i]) word_bins[i] = 0;
    prev_word_ok = 1'b0;
    prev_word = 0;
    seen_count = 0;
    head_pos = 0;
  endfunction

  function automatic int unsigned ring_pos(int unsigned back);
    return (head_pos + RING_DEPTH - (back % RING_DEPTH)) % RING_DEPTH;
  endfunction

  function automatic int unsigned seg_bound(int unsigned k, int unsigned wl, int unsigned wd);
    return (2 * k * wl + wd) / (2 * wd);
  endfunction

  function automatic int unsigned window_word(int unsigned wl, int unsigned wd);
    longint s, q, t, d, dm;
    logic signed [127:0] v, lhs, rhs, big_s, big_d;
    int unsigned w, lo, hi, len, sym;
    s = prefix_sum[ring_pos(0)] - prefix_sum[ring_pos(wl)];
    q = prefix_sq[ring_pos(0)] - prefix_sq[ring_pos(wl)];
    v = q;
    big_s = s;
    v = v * wl - big_s * big_s;
    w = 0;
    for (int unsigned k = 0; k < wd; k++) begin
      lo = seg_bound(k, wl, wd);
      hi = seg_bound(k + 1, wl, wd);
      len = hi - lo;
      if (v == 0) begin
        sym = 3;
      end else begin
        t = prefix_sum[ring_pos(wl - hi)] - prefix_sum[ring_pos(wl - lo)];
        d = t * longint'(wl) - s * longint'(len);
        dm = (d < 0 ? -d : d) * 100;
        big_d = dm;
        lhs = big_d * big_d;
        rhs = v * 4489 * len * len;
        if (d < 0) sym = (lhs > rhs) ? 0 : 1;
        else sym = (lhs < rhs) ? 2 : 3;
      end
      w |= sym << (2 * k);
    end
    return w & ((1 << HIST_AW) - 1);
  endfunction

  function automatic swh_out_t histogram_result(swh_in_t it);
    swh_out_t r;
    int unsigned wd, wl, prev;
    longint x;
    r = '0;
    if (it.op) begin
      r.bin_count = CNT_W'(word_bins[it.bin_index]);
      n_reads++;
    end else begin
      x = it.sample;
      wd = word_len_reg;
      wl = window_len_reg;
      if (it.series_start) clear_series_state();
      prev = head_pos;
      head_pos = (head_pos + 1) % RING_DEPTH;
      prefix_sum[head_pos] = prefix_sum[prev] + x;
      prefix_sq[head_pos] = prefix_sq[prev] + x * x;
      if (seen_count < SEEN_MAX) seen_count++;
      if (wd < 1) wd = 1;
      if (wd > WORD_MAX) wd = WORD_MAX;
      if (wl < 2) wl = 2;
      if (wl < wd) wl = wd;
      if (wl > WINDOW_MAX) wl = WINDOW_MAX;
      n_samples++;
      if (seen_count >= wl) begin
        r.word_valid = 1'b1;
        r.word = HIST_AW'(window_word(wl, wd));
        n_words++;
        if (!prev_word_ok || prev_word != r.word) begin
          r.counted = 1'b1;
          if (word_bins[r.word] < COUNT_MAX) word_bins[r.word]++;
          prev_word = r.word;
          prev_word_ok = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic send_item(swh_in_t it);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    expected_q.insert(expected_q.size(), histogram_result(it));
  endtask

  task automatic push_sample(logic signed [SAMPLE_W-1:0] s, bit start = 1'b0);
    swh_in_t it;
    it = '0;
    it.sample = s;
    it.series_start = start;
    it.bin_index = 14'($urandom);
    if (start) n_series++;
    send_item(it);
  endtask

  task automatic read_bin(logic [HIST_AW-1:0] idx);
    swh_in_t it;
    it.op = 1'b1;
    it.sample = 16'($urandom);
    it.series_start = 1'($urandom);
    it.bin_index = idx;
    send_item(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_cfg(bit idx, logic [WL_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_WORD_LEN) word_len_reg = val[WD_W-1:0];
    else window_len_reg = val;
  endtask

  task automatic set_shape(logic [WL_W-1:0] wd, logic [WL_W-1:0] wl);
    wait_idle();
    write_cfg(1'(CFG_WORD_LEN), wd);
    write_cfg(1'(CFG_WINDOW_LEN), wl);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 40)) - 20);
      2: return 16'(int'($urandom_range(0, 2000)) - 1000);
      default: return $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
    endcase
  endfunction

  task automatic test_default_shape();
    push_sample(16'sh7fff, 1'b1);
    push_sample(-16'sh8000);
    push_sample(16'sd0);
    push_sample(-16'sd1);
    push_sample(16'sd1);
    for (int i = 0; i < 8; i++) push_sample(rand_sample());
    read_bin('0);
    read_bin('1);
  endtask

  task automatic test_flat_window();
    push_sample(-16'sh8000, 1'b1);
    repeat (11) push_sample(-16'sh8000);
    read_bin(14'h3f);
  endtask

  task automatic test_clamped_shape();
    set_shape(11'd0, 11'd0);
    push_sample(16'sd5, 1'b1);
    repeat (6) push_sample(rand_sample());
    set_shape(11'd7, 11'd1);
    repeat (10) push_sample(rand_sample());
    read_bin(14'h3fff);
  endtask

  task automatic test_repeat_pattern();
    set_shape(11'd2, 11'd4);
    push_sample(16'sd0, 1'b1);
    for (int i = 0; i < 40; i++) push_sample((i % 4) < 2 ? 16'sd100 : -16'sd100);
    for (int i = 0; i < 16; i++) read_bin(14'(i));
  endtask

  task automatic test_long_window();
    set_shape(11'd7, 11'd120);
    push_sample(rand_sample(), 1'b1);
    for (int i = 0; i < 129; i++) push_sample(rand_sample());
    read_bin(14'(prev_word));
  endtask

  task automatic test_output_hold();
    set_shape(11'd3, 11'd8);
    hold_len = 400;
    quiet_send = 1'b1;
    push_sample(rand_sample(), 1'b1);
    repeat (20) push_sample(rand_sample());
    quiet_send = 1'b0;
  endtask

  task automatic test_random_series();
    for (int ph = 0; ph < 8; ph++) begin
      set_shape(11'($urandom_range(1, 7)), 11'($urandom_range(0, 3) == 0 ?
                $urandom_range(0, 200) : $urandom_range(2, 24)));
      quiet_send = ph[0];
      quiet_recv = ph[1];
      if (ph % 2 == 0) push_sample(rand_sample(), 1'b1);
      for (int i = 0; i < 20; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          read_bin($urandom_range(0, 1) ? 14'($urandom) : 14'(prev_word));
        end else begin
          push_sample(rand_sample());
        end
      end
    end
    quiet_send = 1'b0;
    quiet_recv = 1'b0;
  endtask

  // result side: random stalls and the long hold-off
  initial begin
    int n;
    forever begin
      n = hold_len > 0 ? hold_len : (quiet_recv ? 0 : $urandom_range(0, 16));
      hold_len = 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    swh_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_data.word_valid !== exp_r.word_valid) begin
          $display("%0t: word_valid expected %0d actual %0d", $time,
                   exp_r.word_valid, out_data.word_valid);
          errors++;
        end
        if (out_data.word !== exp_r.word) begin
          $display("%0t: word expected %h actual %h", $time, exp_r.word, out_data.word);
          errors++;
        end
        if (out_data.counted !== exp_r.counted) begin
          $display("%0t: counted expected %0d actual %0d", $time,
                   exp_r.counted, out_data.counted);
          errors++;
        end
        if (out_data.bin_count !== exp_r.bin_count) begin
          $display("%0t: bin_count expected %0d actual %0d", $time,
                   exp_r.bin_count, out_data.bin_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sax_word_histogram_unit: mismatch");
      $finish;
    end
  end

  initial begin
    clear_series_state();
    word_len_reg = WD_W'(3);
    window_len_reg = WL_W'(10);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_default_shape();
    wait_idle();
    test_flat_window();
    test_clamped_shape();
    test_repeat_pattern();
    test_long_window();
    test_output_hold();
    test_random_series();
    wait_idle();
    if (expected_q.size() != 0) errors++;
    $display("covered %0d samples (%0d full windows), %0d bin reads, %0d series starts",
             n_samples, n_words, n_reads, n_series);
    $display("word lengths 0..7 and window lengths 0..200 including clamped values");
    if (errors == 0) begin
      $display("sax_word_histogram_unit: match");
    end else begin
      $display("sax_word_histogram_unit: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
sv/swh_pkg.sv
sv/swh_mul.sv
sv/swh_dp.sv
sv/swh_ctrl.sv
sv/sax_word_histogram_unit.sv
sv/swh_chk.sv
bench/sax_word_histogram_unit_tb.sv
